// File: sv/assert_macros.svh
// Assertion macros shared by the pulse train decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OOK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OOK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ooktd_pkg.sv
// Package: constants, protocol table and shared types of the pulse train decoder.
package ooktd_pkg;

  // Default sizes
  localparam int unsigned NUM_PROTOCOLS_DEF  = 7;
  localparam int unsigned CODE_WIDTH_DEF     = 32;
  localparam int unsigned DURATION_WIDTH_DEF = 15;
  localparam int unsigned COUNT_WIDTH_DEF    = 10;

  // Fixed sizes
  localparam int unsigned TABLE_SIZE    = 7;
  localparam int unsigned PERCENT_SCALE = 100;
  localparam int unsigned PCT_W         = 7;
  localparam int unsigned MIN_ITEMS_W   = 10;
  localparam int unsigned CFG_DATA_W    = 10;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned PIDX_W        = 3;
  localparam int unsigned SYM_W         = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ITEMS = 1'd1;
  localparam logic [PCT_W-1:0]       TOL_PCT_RESET   = 7'd60;
  localparam logic [MIN_ITEMS_W-1:0] MIN_ITEMS_RESET = 10'd10;

  // Symbol times in base pulses; the sync symbol plays no part in decoding
  typedef struct packed {
    logic [SYM_W-1:0] zero_hi;
    logic [SYM_W-1:0] zero_lo;
    logic [SYM_W-1:0] one_hi;
    logic [SYM_W-1:0] one_lo;
    logic             inv;
  } proto_t;

  localparam proto_t PROTO_TABLE [TABLE_SIZE] = '{
    '{4'd1, 4'd3,  4'd3, 4'd1, 1'b0},
    '{4'd1, 4'd2,  4'd2, 4'd1, 1'b0},
    '{4'd4, 4'd11, 4'd9, 4'd6, 1'b0},
    '{4'd1, 4'd3,  4'd3, 4'd1, 1'b0},
    '{4'd1, 4'd2,  4'd2, 4'd1, 1'b0},
    '{4'd1, 4'd2,  4'd2, 4'd1, 1'b1},
    '{4'd1, 4'd6,  4'd6, 4'd1, 1'b0}
  };

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CLASSIFY,
    ST_FINISH
  } back_state_e;

  // Pulse count of the symbol that is long in the longer half of the first item
  function automatic logic [SYM_W-1:0] proto_div(input logic [PIDX_W-1:0] idx,
                                                 input logic first_longer);
    proto_t           pr;
    logic [SYM_W-1:0] d;
    pr = PROTO_TABLE[idx];
    if (first_longer) begin
      d = (pr.zero_hi > pr.zero_lo) ? pr.zero_hi : pr.one_hi;
    end else begin
      d = (pr.zero_hi < pr.zero_lo) ? pr.zero_lo : pr.one_lo;
    end
    if (d == '0) begin
      d = SYM_W'(1);
    end
    return d;
  endfunction

endpackage

// File: sv/ooktd_if.sv
// Channel interfaces: pulse item input and decode result output.
interface ooktd_in_if #(
  parameter int unsigned DURATION_WIDTH = 15
);
  logic                      valid;
  logic                      ready;
  logic                      first_level;
  logic [DURATION_WIDTH-1:0] first_duration;
  logic                      second_level;
  logic [DURATION_WIDTH-1:0] second_duration;
  logic                      last_item;

  modport source (
    output valid, first_level, first_duration, second_level, second_duration, last_item,
    input  ready
  );
  modport sink (
    input  valid, first_level, first_duration, second_level, second_duration, last_item,
    output ready
  );
endinterface

interface ooktd_out_if #(
  parameter int unsigned CODE_WIDTH     = 32,
  parameter int unsigned DURATION_WIDTH = 15,
  parameter int unsigned COUNT_WIDTH    = 10
);
  logic                      valid;
  logic                      ready;
  logic                      decoded;
  logic [2:0]                protocol_index;
  logic [CODE_WIDTH-1:0]     code;
  logic [COUNT_WIDTH-1:0]    item_count;
  logic [DURATION_WIDTH-1:0] pulse_length;

  modport source (
    output valid, decoded, protocol_index, code, item_count, pulse_length,
    input  ready
  );
  modport sink (
    input  valid, decoded, protocol_index, code, item_count, pulse_length,
    output ready
  );
endinterface

// File: sv/ook_remote_pulse_train_decoder_unit.sv
// Top level of the on-off keyed remote pulse train decoder.
//
// Pulse items enter on in_chan (valid/ready); a transfer takes place at a clock
// edge with valid and ready both high. Each item carries two line levels, two
// durations and a last flag that closes the burst. One result per burst leaves
// on out_chan (valid/ready) after the last item: decoded, the lowest matching
// protocol, its code, the item count and the derived base pulse length.
// Flow: a first item runs per-protocol setup in a pipeline, then, unless it is
// the last, bit classification, each for the NP protocols in use (7 by
// default). Any later item runs bit classification for each protocol; the last
// item goes to the result register. A two-entry queue in front lets the input
// keep transferring while the back end works.
// Reset clears the queue, the burst position, the output register and returns
// tolerance_percent to 60 and min_items to 10. If the receiver stalls, the
// result stays in the output register; the back end keeps working on further
// items and only waits when the next result is due.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 tolerance_percent, 1 min_items); the user must write only while the
// block is idle. The block itself does not enforce this.
module ook_remote_pulse_train_decoder_unit
  import ooktd_pkg::*;
#(
  parameter int unsigned NUM_PROTOCOLS  = NUM_PROTOCOLS_DEF,
  parameter int unsigned CODE_WIDTH     = CODE_WIDTH_DEF,
  parameter int unsigned DURATION_WIDTH = DURATION_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ooktd_in_if.sink              in_chan,
  ooktd_out_if.source           out_chan,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef struct packed {
    logic                      first;
    logic                      last;
    logic                      first_longer;
    logic [DURATION_WIDTH-1:0] longer;
    logic                      first_level;
    logic                      second_level;
    logic [DURATION_WIDTH-1:0] first_duration;
    logic [DURATION_WIDTH-1:0] second_duration;
    logic [COUNT_WIDTH-1:0]    count;
  } item_t;

  logic [PCT_W-1:0]       tol_pct_q;
  logic [MIN_ITEMS_W-1:0] min_items_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_pct_q   <= TOL_PCT_RESET;
      min_items_q <= MIN_ITEMS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOLERANCE: tol_pct_q   <= cfg_data_i[PCT_W-1:0];
        CFG_MIN_ITEMS: min_items_q <= cfg_data_i[MIN_ITEMS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic  push_vld, push_rdy;
  item_t push_item;
  logic  pop_vld, pop_rdy;
  item_t pop_item;

  ooktd_front #(
    .DURATION_WIDTH (DURATION_WIDTH),
    .COUNT_WIDTH    (COUNT_WIDTH),
    .item_t         (item_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan),
    .push_vld_o  (push_vld),
    .push_item_o (push_item),
    .push_rdy_i  (push_rdy)
  );

  ooktd_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (item_t)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (push_vld),
    .push_item_i (push_item),
    .push_rdy_o  (push_rdy),
    .pop_vld_o   (pop_vld),
    .pop_item_o  (pop_item),
    .pop_rdy_i   (pop_rdy)
  );

  ooktd_back #(
    .NUM_PROTOCOLS  (NUM_PROTOCOLS),
    .CODE_WIDTH     (CODE_WIDTH),
    .DURATION_WIDTH (DURATION_WIDTH),
    .COUNT_WIDTH    (COUNT_WIDTH),
    .item_t         (item_t)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_vld_i   (pop_vld),
    .pop_item_i  (pop_item),
    .pop_rdy_o   (pop_rdy),
    .tol_pct_i   (tol_pct_q),
    .min_items_i (min_items_q),
    .out_chan    (out_chan)
  );

endmodule

// File: sv/ooktd_front.sv
// Front end: accepts pulse items, tracks burst position and count, classifies halves.
`include "assert_macros.svh"

module ooktd_front
  import ooktd_pkg::*;
#(
  parameter int unsigned DURATION_WIDTH = DURATION_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter type         item_t         = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ooktd_in_if.sink in_chan,
  output logic  push_vld_o,
  output item_t push_item_o,
  input  logic  push_rdy_i
);

  localparam int unsigned DW = DURATION_WIDTH;

  logic                   burst_open_q, burst_open_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] count_new;
  logic                   xfer;
  logic                   first_longer;

  assign in_chan.ready = push_rdy_i;
  assign push_vld_o    = in_chan.valid;
  assign xfer          = in_chan.valid && push_rdy_i;

  // Count this item: restart at one on a new burst, else add one, saturating
  always_comb begin
    if (!burst_open_q) begin
      count_new = COUNT_WIDTH'(1);
    end else if (count_q == '1) begin
      count_new = count_q;
    end else begin
      count_new = count_q + COUNT_WIDTH'(1);
    end
    burst_open_d = burst_open_q;
    count_d      = count_q;
    if (xfer) begin
      burst_open_d = !in_chan.last_item;
      count_d      = in_chan.last_item ? '0 : count_new;
    end
  end

  // Classify the item for the back end
  assign first_longer = in_chan.first_duration > in_chan.second_duration;

  always_comb begin
    push_item_o.first           = !burst_open_q;
    push_item_o.last            = in_chan.last_item;
    push_item_o.first_longer    = first_longer;
    push_item_o.longer          = first_longer ? in_chan.first_duration
                                               : in_chan.second_duration;
    push_item_o.first_level     = in_chan.first_level;
    push_item_o.second_level    = in_chan.second_level;
    push_item_o.first_duration  = in_chan.first_duration;
    push_item_o.second_duration = in_chan.second_duration;
    push_item_o.count           = count_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_open_q <= 1'b0;
      count_q      <= '0;
    end else begin
      burst_open_q <= burst_open_d;
      count_q      <= count_d;
    end
  end

  `OOK_ASSERT_IMP(a_count_idle_zero, !burst_open_q, count_q == '0,
                  "item count not cleared between bursts")

endmodule

// File: sv/ooktd_queue.sv
// Short item queue between the front end and the back end.
`include "assert_macros.svh"

module ooktd_queue
  import ooktd_pkg::*;
#(
  parameter int unsigned DEPTH  = QUEUE_DEPTH,
  parameter type         item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_vld_i,
  input  item_t push_item_i,
  output logic  push_rdy_o,
  output logic  pop_vld_o,
  output item_t pop_item_o,
  input  logic  pop_rdy_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_rdy_o = cnt_q != CW'(DEPTH);
  assign pop_vld_o  = cnt_q != '0;
  assign pop_item_o = slot_q[rd_ptr_q];
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_vld_o && pop_rdy_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  `OOK_ASSERT_IMP(a_queue_bound, 1'b1, cnt_q <= CW'(DEPTH),
                  "queue occupancy beyond depth")

endmodule

// File: sv/ooktd_back.sv
// Back end: per-protocol setup, bit classification and result selection.
`include "assert_macros.svh"

module ooktd_back
  import ooktd_pkg::*;
#(
  parameter int unsigned NUM_PROTOCOLS  = NUM_PROTOCOLS_DEF,
  parameter int unsigned CODE_WIDTH     = CODE_WIDTH_DEF,
  parameter int unsigned DURATION_WIDTH = DURATION_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter type         item_t         = logic
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_vld_i,
  input  item_t                  pop_item_i,
  output logic                   pop_rdy_o,
  input  logic [PCT_W-1:0]       tol_pct_i,
  input  logic [MIN_ITEMS_W-1:0] min_items_i,
  ooktd_out_if.source            out_chan
);

  localparam int unsigned NP   = (NUM_PROTOCOLS < TABLE_SIZE) ? NUM_PROTOCOLS : TABLE_SIZE;
  localparam int unsigned IW   = (NP > 1) ? $clog2(NP) : 1;
  localparam int unsigned DW   = DURATION_WIDTH;
  localparam int unsigned RW   = DW + 1;
  localparam int unsigned XW   = DW + PCT_W;
  localparam int unsigned MW   = XW - 6;
  localparam int unsigned TW   = DW + SYM_W;
  localparam int unsigned CMPW = (COUNT_WIDTH > MIN_ITEMS_W) ? COUNT_WIDTH : MIN_ITEMS_W;
  localparam logic [MW-1:0] RECIP_100 = MW'((64'd1 << XW) / PERCENT_SCALE);

  // True when d lies strictly within tol of tgt
  function automatic logic near(input logic [DW-1:0] d, input logic [TW-1:0] tgt,
                                input logic [DW-1:0] tol);
    logic [TW-1:0] dx;
    logic [TW-1:0] dv;
    dx = TW'(d);
    dv = (dx > tgt) ? (dx - tgt) : (tgt - dx);
    return dv < TW'(tol);
  endfunction

  // Reciprocals of the base pulse divisors, per protocol and longer half
  logic [RW-1:0] recip_fl [NP];
  logic [RW-1:0] recip_sl [NP];

  for (genvar g = 0; g < NP; g++) begin : g_recip
    localparam int unsigned DivFl = int'(proto_div(PIDX_W'(g), 1'b1));
    localparam int unsigned DivSl = int'(proto_div(PIDX_W'(g), 1'b0));
    localparam logic [RW-1:0] RecipFl = RW'((64'd1 << DW) / DivFl);
    localparam logic [RW-1:0] RecipSl = RW'((64'd1 << DW) / DivSl);
    assign recip_fl[g] = RecipFl;
    assign recip_sl[g] = RecipSl;
  end

  back_state_e state_q, state_d;
  item_t       cur_q;
  logic        load_item;
  logic [IW-1:0] iss_q, iss_d;
  logic          iss_on_q, iss_on_d;
  logic          iss_last;

  // Per-protocol burst state
  logic [DW-1:0]         base_q [NP];
  logic [DW-1:0]         tol_q  [NP];
  logic [CODE_WIDTH-1:0] code_q [NP];
  logic [NP-1:0]         match_q;

  // Setup pipeline
  logic             s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [IW-1:0]    s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [DW+RW-1:0] s1_prod_q;
  logic [SYM_W-1:0] s1_div_q;
  logic [DW-1:0]    s2_base_q, s3_base_q, s4_base_q;
  logic [XW-1:0]    s3_x_q, s4_x_q;
  logic [XW+MW-1:0] s4_prod_q;
  logic             setup_busy;

  // Classify pipeline
  logic          c1_vld_q;
  logic [IW-1:0] c1_idx_q;
  logic [DW-1:0] c1_tol_q;
  logic [TW-1:0] tgt_zh_q, tgt_zl_q, tgt_oh_q, tgt_ol_q;

  // Output register
  logic                   out_vld_q;
  logic                   o_dec_q;
  logic [PIDX_W-1:0]      o_idx_q;
  logic [CODE_WIDTH-1:0]  o_code_q;
  logic [COUNT_WIDTH-1:0] o_cnt_q;
  logic [DW-1:0]          o_pulse_q;
  logic                   out_load;
  logic                   out_free;

  // Shared read ports of the per-protocol state
  logic [IW-1:0]         sel_idx;
  logic [IW-1:0]         base_rd_idx;
  logic [IW-1:0]         code_rd_idx;
  logic [DW-1:0]         base_rd;
  logic [CODE_WIDTH-1:0] code_rd;

  assign iss_last   = iss_q == IW'(NP - 1);
  assign setup_busy = iss_on_q || s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q;
  assign out_free   = !out_vld_q || out_chan.ready;

  // Sequencer: next state, issue counter, transfers
  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    iss_on_d  = iss_on_q;
    pop_rdy_o = 1'b0;
    load_item = 1'b0;
    out_load  = 1'b0;
    if (iss_on_q) begin
      iss_d    = iss_last ? '0 : iss_q + IW'(1);
      iss_on_d = !iss_last;
    end
    case (state_q)
      ST_IDLE: begin
        pop_rdy_o = 1'b1;
        if (pop_vld_i) begin
          load_item = 1'b1;
          iss_d     = '0;
          if (pop_item_i.first) begin
            state_d  = ST_SETUP;
            iss_on_d = 1'b1;
          end else if (pop_item_i.last) begin
            state_d = ST_FINISH;
          end else begin
            state_d  = ST_CLASSIFY;
            iss_on_d = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        if (!setup_busy) begin
          iss_d = '0;
          if (cur_q.last) begin
            state_d = ST_FINISH;
          end else begin
            state_d  = ST_CLASSIFY;
            iss_on_d = 1'b1;
          end
        end
      end
      ST_CLASSIFY: begin
        if (!iss_on_q && !c1_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      iss_q    <= '0;
      iss_on_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      iss_on_q <= iss_on_d;
    end
  end

  // Hold the item under work
  always_ff @(posedge clk_i) begin
    if (load_item) begin
      cur_q <= pop_item_i;
    end
  end

  // Setup stage 1: multiply the longer half by the divisor reciprocal
  logic [RW-1:0]    recip_sel;
  logic [SYM_W-1:0] div_sel;

  assign recip_sel = cur_q.first_longer ? recip_fl[iss_q] : recip_sl[iss_q];
  assign div_sel   = proto_div(PIDX_W'(iss_q), cur_q.first_longer);

  // Setup stage 2: correct the quotient into the base pulse
  logic [DW-1:0]       q_est;
  logic [DW+SYM_W-1:0] q_back;
  logic [DW:0]         q_rem;
  logic [DW-1:0]       base_new;

  assign q_est    = s1_prod_q[2*DW-1:DW];
  assign q_back   = (DW+SYM_W)'(q_est) * (DW+SYM_W)'(s1_div_q);
  assign q_rem    = (DW+1)'(cur_q.longer) - q_back[DW:0];
  assign base_new = q_est + DW'(q_rem >= (DW+1)'(s1_div_q));

  // Setup stage 3 input: clamp the tolerance percentage
  logic [PCT_W-1:0] pct_eff;

  assign pct_eff = (tol_pct_i > PCT_W'(PERCENT_SCALE)) ? PCT_W'(PERCENT_SCALE) : tol_pct_i;

  // Setup write back: correct the tolerance quotient, check polarity
  logic [MW-1:0] t_est;
  logic [XW-1:0] t_back;
  logic [XW-1:0] t_rem;
  logic [MW-1:0] tol_full;
  proto_t        pr_wb;
  logic          pol_bad;

  assign t_est    = s4_prod_q[XW+MW-1:XW];
  assign t_back   = XW'(t_est) * XW'(PERCENT_SCALE);
  assign t_rem    = s4_x_q - t_back;
  assign tol_full = t_est + MW'(t_rem >= XW'(PERCENT_SCALE));
  assign pr_wb    = PROTO_TABLE[PIDX_W'(s4_idx_q)];
  assign pol_bad  = pr_wb.inv ? (cur_q.first_level && !cur_q.second_level)
                              : (!cur_q.first_level && cur_q.second_level);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= (state_q == ST_SETUP) && iss_on_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= iss_q;
    s1_prod_q <= (DW+RW)'(cur_q.longer) * (DW+RW)'(recip_sel);
    s1_div_q  <= div_sel;
    s2_idx_q  <= s1_idx_q;
    s2_base_q <= base_new;
    s3_idx_q  <= s2_idx_q;
    s3_base_q <= s2_base_q;
    s3_x_q    <= XW'(s2_base_q) * XW'(pct_eff);
    s4_idx_q  <= s3_idx_q;
    s4_base_q <= s3_base_q;
    s4_x_q    <= s3_x_q;
    s4_prod_q <= (XW+MW)'(s3_x_q) * (XW+MW)'(RECIP_100);
  end

  // Classify stage 1: scale the symbol times by the base pulse
  proto_t pr_iss;

  assign pr_iss = PROTO_TABLE[PIDX_W'(iss_q)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
    end else begin
      c1_vld_q <= (state_q == ST_CLASSIFY) && iss_on_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_idx_q <= iss_q;
    c1_tol_q <= tol_q[iss_q];
    tgt_zh_q <= TW'(base_rd) * TW'(pr_iss.zero_hi);
    tgt_zl_q <= TW'(base_rd) * TW'(pr_iss.zero_lo);
    tgt_oh_q <= TW'(base_rd) * TW'(pr_iss.one_hi);
    tgt_ol_q <= TW'(base_rd) * TW'(pr_iss.one_lo);
  end

  // Classify stage 2: zero bit, one bit or drop the protocol
  logic                  is_zero, is_one;
  logic [CODE_WIDTH-1:0] code_shift;

  assign is_zero    = near(cur_q.first_duration, tgt_zh_q, c1_tol_q)
                   && near(cur_q.second_duration, tgt_zl_q, c1_tol_q);
  assign is_one     = near(cur_q.first_duration, tgt_oh_q, c1_tol_q)
                   && near(cur_q.second_duration, tgt_ol_q, c1_tol_q);
  assign code_shift = {code_rd[CODE_WIDTH-2:0], 1'b0};

  // Finish: lowest numbered protocol still matching
  always_comb begin
    sel_idx = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        sel_idx = IW'(i);
      end
    end
  end

  assign base_rd_idx = (state_q == ST_FINISH) ? sel_idx : iss_q;
  assign code_rd_idx = (state_q == ST_FINISH) ? sel_idx : c1_idx_q;
  assign base_rd     = base_q[base_rd_idx];
  assign code_rd     = code_q[code_rd_idx];

  // Write per-protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '1;
    end else if (s4_vld_q) begin
      match_q[s4_idx_q] <= !pol_bad;
    end else if (c1_vld_q && match_q[c1_idx_q] && !is_zero && !is_one) begin
      match_q[c1_idx_q] <= 1'b0;
    end else if (out_load) begin
      match_q <= '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_vld_q) begin
      base_q[s4_idx_q] <= s4_base_q;
      tol_q[s4_idx_q]  <= tol_full[DW-1:0];
      code_q[s4_idx_q] <= '0;
    end else if (c1_vld_q && match_q[c1_idx_q]) begin
      code_q[c1_idx_q] <= code_shift | CODE_WIDTH'(!is_zero && is_one);
    end
  end

  // Result register
  logic ok;

  assign ok = (|match_q) && (cur_q.second_duration == '0)
           && (CMPW'(cur_q.count) >= CMPW'(min_items_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_dec_q   <= ok;
      o_idx_q   <= ok ? PIDX_W'(sel_idx) : '0;
      o_code_q  <= ok ? code_rd : '0;
      o_cnt_q   <= ok ? cur_q.count : '0;
      o_pulse_q <= ok ? base_rd : '0;
    end
  end

  assign out_chan.valid          = out_vld_q;
  assign out_chan.decoded        = o_dec_q;
  assign out_chan.protocol_index = o_idx_q;
  assign out_chan.code           = o_code_q;
  assign out_chan.item_count     = o_cnt_q;
  assign out_chan.pulse_length   = o_pulse_q;

  `OOK_ASSERT_IMP(a_setup_in_state, s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q,
                  state_q == ST_SETUP, "setup pipeline active outside setup")
  `OOK_ASSERT_IMP(a_classify_in_state, c1_vld_q, state_q == ST_CLASSIFY,
                  "classify stage active outside classify")
  `OOK_ASSERT_IMP(a_result_from_finish, $rose(out_vld_q), $past(state_q) == ST_FINISH,
                  "result raised without a finished burst")

endmodule
